[rtl/core/command_frame_receiver_queue_core_defines.svh]
// assertion macros shared by the command frame receiver rtl
// no dependencies; included by files that carry concurrent checks
`ifndef COMMAND_FRAME_RECEIVER_QUEUE_CORE_DEFINES_SVH
`define COMMAND_FRAME_RECEIVER_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CFRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfrq check failed");

// next-cycle implication, disabled while reset is low
`define CFRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfrq check failed");

`endif

[rtl/core/cfrq_pkg.sv]
// types and constants for the command frame receiver queue
// no dependencies; imported by the interfaces and all modules
package cfrq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // frame layout
    localparam int BYTE_BITS    = 8;
    localparam int HDR_BYTES    = 4;
    localparam int POS_MODULE   = 0;
    localparam int POS_FUNCTION = 1;
    localparam int LEN_LO_POS   = 2;
    localparam int LEN_HI_POS   = 3;
    localparam int POS_W        = 17;
    localparam int LEN_W        = 16;
    localparam int QCOUNT_W     = 5;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] mod_id;
        logic [BYTE_BITS-1:0] func_id;
        logic [LEN_W-1:0]     len;
    } hdr_t;

    // parser status for the byte on the input
    typedef struct packed {
        logic             payload_valid;
        logic [LEN_W-1:0] payload_index;
        logic             frame_done;
        hdr_t             hdr;
    } parse_t;

    // queue status before the current beat is applied, with the count after it
    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count_next;
        hdr_t             head;
    } qstat_t;

    // one result beat
    typedef struct packed {
        logic                 payload_valid;
        logic [BYTE_BITS-1:0] payload_byte;
        logic [LEN_W-1:0]     payload_index;
        logic                 frame_done;
        logic                 frame_dropped;
        logic                 cmd_valid;
        logic [BYTE_BITS-1:0] cmd_target;
        logic [BYTE_BITS-1:0] cmd_function;
        logic [LEN_W-1:0]     cmd_length;
        logic                 pop_error;
        logic [QCOUNT_W-1:0]  queue_count;
        logic                 queue_full;
    } result_t;

endpackage

[rtl/core/cfrq_req_if.sv]
// request channel: serial byte or pop beat with valid/ready
// depends on cfrq_pkg
interface cfrq_req_if
    import cfrq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [BYTE_BITS-1:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

[rtl/core/cfrq_rsp_if.sv]
// result channel: one beat per accepted request, valid/ready
// depends on cfrq_pkg
interface cfrq_rsp_if
    import cfrq_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 payload_valid;
    logic [BYTE_BITS-1:0] payload_byte;
    logic [LEN_W-1:0]     payload_index;
    logic                 frame_done;
    logic                 frame_dropped;
    logic                 cmd_valid;
    logic [BYTE_BITS-1:0] cmd_target;
    logic [BYTE_BITS-1:0] cmd_function;
    logic [LEN_W-1:0]     cmd_length;
    logic                 pop_error;
    logic [QCOUNT_W-1:0]  queue_count;
    logic                 queue_full;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_done, output frame_dropped, output cmd_valid, output cmd_target,
        output cmd_function, output cmd_length, output pop_error, output queue_count,
        output queue_full, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_done, input frame_dropped, input cmd_valid, input cmd_target,
        input cmd_function, input cmd_length, input pop_error, input queue_count,
        input queue_full, output ready
    );
endinterface

[rtl/core/cfrq_parser.sv]
// frame header / payload parser, one byte per enable
// depends on cfrq_pkg
module cfrq_parser
    import cfrq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_en,
    input  logic [BYTE_BITS-1:0] rx_byte,
    output parse_t               status
);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [BYTE_BITS-1:0] mod_reg, mod_next;
    logic [BYTE_BITS-1:0] func_reg, func_next;

    logic [POS_W-1:0]     pos_inc;
    logic [LEN_W-1:0]     len_new;
    logic [BYTE_BITS-1:0] mod_new;
    logic [BYTE_BITS-1:0] func_new;
    logic                 in_payload;
    logic                 done;

    always_comb
    begin
        pos_inc    = pos_reg + POS_W'(1);
        in_payload = (pos_reg >= POS_W'(HDR_BYTES));
        mod_new    = (pos_reg == POS_W'(POS_MODULE)) ? rx_byte : mod_reg;
        func_new   = (pos_reg == POS_W'(POS_FUNCTION)) ? rx_byte : func_reg;
        if (pos_reg == POS_W'(LEN_LO_POS))
        begin
            len_new = LEN_W'(rx_byte);
        end
        else if (pos_reg == POS_W'(LEN_HI_POS))
        begin
            len_new = {rx_byte, len_reg[BYTE_BITS-1:0]};
        end
        else
        begin
            len_new = len_reg;
        end
        // frame ends once all header and payload bytes are in
        done = (pos_inc >= (POS_W'(HDR_BYTES) + POS_W'(len_new)));

        status.payload_valid = in_payload;
        status.payload_index = in_payload ? LEN_W'(pos_reg - POS_W'(HDR_BYTES)) : '0;
        status.frame_done    = done;
        status.hdr.mod_id    = mod_new;
        status.hdr.func_id   = func_new;
        status.hdr.len       = len_new;

        pos_next  = pos_reg;
        len_next  = len_reg;
        mod_next  = mod_reg;
        func_next = func_reg;
        if (byte_en)
        begin
            pos_next  = done ? '0 : pos_inc;
            len_next  = done ? '0 : len_new;
            mod_next  = mod_new;
            func_next = func_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            len_reg  <= '0;
            mod_reg  <= '0;
            func_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            mod_reg  <= mod_next;
            func_reg <= func_next;
        end
    end

endmodule

[rtl/core/cfrq_queue.sv]
// circular header queue with registered head read
// depends on cfrq_pkg and command_frame_receiver_queue_core_defines.svh
`include "command_frame_receiver_queue_core_defines.svh"

module cfrq_queue
    import cfrq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_req,
    input  hdr_t   push_data,
    input  logic   pop_req,
    output qstat_t status
);

    hdr_t store [QUEUE_DEPTH];
    hdr_t head_reg;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic empty;
    logic full;
    logic push_en;
    logic pop_en;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        empty   = (count_reg == '0);
        full    = (count_reg == CNT_W'(QUEUE_DEPTH));
        push_en = push_req && !full;
        pop_en  = pop_req && !empty;

        wr_ptr_next = push_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        status.empty      = empty;
        status.full       = full;
        status.count_next = count_next;
        status.head       = head_reg;
    end

    // head tracks the entry under the read pointer; a push into an empty
    // queue lands straight in the head
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            store[wr_ptr_reg] <= push_data;
        end
        head_reg <= (push_en && empty) ? push_data : store[rd_ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CFRQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    `CFRQ_ASSERT_NOW(a_empty_ptrs, clk, rst_n, empty, wr_ptr_reg == rd_ptr_reg)
    `CFRQ_ASSERT_NEXT(a_push_count, clk, rst_n, push_req && !full,
        count_reg == $past(count_reg) + CNT_W'(1))
    `CFRQ_ASSERT_NEXT(a_pop_empty_hold, clk, rst_n, pop_req && empty,
        $stable(rd_ptr_reg) && $stable(count_reg))

endmodule

[rtl/core/command_frame_receiver_queue_core.sv]
// command frame receiver queue: top level
// depends on cfrq_pkg, cfrq_req_if, cfrq_rsp_if, cfrq_parser, cfrq_queue
//
// usage
//   req carries one beat per serial byte (operation = byte) or per pop
//   request (operation = pop). frames are module, function, length lo,
//   length hi, then length payload bytes; a zero length ends the frame
//   after the length hi byte.
//   rsp carries exactly one result beat per accepted req beat, in order:
//   payload bytes with their index, frame done / dropped flags, popped
//   headers or a pop error, and the queue fill after the beat.
// result register and throughput
//   a result is registered in the cycle after its req beat is accepted;
//   one beat per cycle is sustained while rsp.ready stays high, the only
//   loop being the parser and queue state that each beat updates.
// reset
//   rst_n low clears the parser position, the queue pointers and count and
//   the result valid; queue entries are not cleared, only written ones are
//   ever read.
// stall
//   while a result waits on rsp and rsp.ready is low, req.ready drops;
//   when the result is taken the next req beat is accepted in that cycle.
module command_frame_receiver_queue_core
    import cfrq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfrq_req_if.sink    req,
    cfrq_rsp_if.source  rsp
);

    logic    accept;
    logic    is_pop;
    logic    byte_en;
    logic    pop_req;
    logic    push_req;
    parse_t  pstat;
    qstat_t  qstat;
    result_t res;

    // result register: valid is control, payload needs no reset
    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    // free to accept while the result slot is empty or being drained
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_pop    = (req.operation == OP_POP);
    assign byte_en   = accept && !is_pop;
    assign pop_req   = accept && is_pop;
    assign push_req  = byte_en && pstat.frame_done;

    cfrq_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .rx_byte (req.rx_byte),
        .status  (pstat)
    );

    cfrq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_req  (push_req),
        .push_data (pstat.hdr),
        .pop_req   (pop_req),
        .status    (qstat)
    );

    // build the result beat for the request on the input
    always_comb
    begin
        res = '0;
        if (!is_pop)
        begin
            res.payload_valid = pstat.payload_valid;
            res.payload_byte  = pstat.payload_valid ? req.rx_byte : '0;
            res.payload_index = pstat.payload_index;
            res.frame_done    = pstat.frame_done;
            // frame complete but no room left: header is thrown away
            res.frame_dropped = pstat.frame_done && qstat.full;
        end
        else if (qstat.empty)
        begin
            res.pop_error = 1'b1;
        end
        else
        begin
            res.cmd_valid    = 1'b1;
            res.cmd_target   = qstat.head.mod_id;
            res.cmd_function = qstat.head.func_id;
            res.cmd_length   = qstat.head.len;
        end
        // count field wraps for deep queues, full flag stays exact
        res.queue_count = QCOUNT_W'(qstat.count_next);
        res.queue_full  = (qstat.count_next == CNT_W'(QUEUE_DEPTH));
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    // result channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.payload_valid = res_reg.payload_valid;
    assign rsp.payload_byte  = res_reg.payload_byte;
    assign rsp.payload_index = res_reg.payload_index;
    assign rsp.frame_done    = res_reg.frame_done;
    assign rsp.frame_dropped = res_reg.frame_dropped;
    assign rsp.cmd_valid     = res_reg.cmd_valid;
    assign rsp.cmd_target    = res_reg.cmd_target;
    assign rsp.cmd_function  = res_reg.cmd_function;
    assign rsp.cmd_length    = res_reg.cmd_length;
    assign rsp.pop_error     = res_reg.pop_error;
    assign rsp.queue_count   = res_reg.queue_count;
    assign rsp.queue_full    = res_reg.queue_full;

endmodule

[bench/command_frame_receiver_queue_core_tb.sv]
// self-checking bench for the command frame receiver queue core
// depends on cfrq_pkg, cfrq_req_if, cfrq_rsp_if and the core rtl
`timescale 1ns / 1ps

module command_frame_receiver_queue_core_tb;
    import cfrq_pkg::*;

    localparam int RANDOM_ITEMS   = 1400;
    localparam int HOLD_AFTER     = 500;  // results seen before the long receiver hold
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 20;
    localparam int FRAMES_PER_RUN = 20;

    // one queued request beat, or a marker that makes the sender wait for all results
    typedef struct packed {
        logic                 drain;
        op_t                  op;
        logic [BYTE_BITS-1:0] data;
    } rx_item_t;

    logic clk = 1'b0;
    logic rst_n;

    cfrq_req_if req_ch ();
    cfrq_rsp_if rsp_ch ();

    command_frame_receiver_queue_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    rx_item_t tx_beats[$];
    result_t  due_results[$];

    // predicted parser and header queue state
    int                   rx_pos;
    logic [LEN_W-1:0]     rx_len;
    logic [BYTE_BITS-1:0] rx_mod;
    logic [BYTE_BITS-1:0] rx_func;
    hdr_t                 hdr_ring [QUEUE_DEPTH];
    int                   ring_wr;
    int                   ring_rd;
    int                   ring_fill;

    int       send_gap;
    int       stall_left;
    bit       hold_done;
    int       results_seen;
    int       error_count;
    rx_item_t next_item;
    result_t  seen;
    result_t  want;
    string    bad_fields;

    initial begin
        forever #4 clk = ~clk;
    end

    // parses one beat and updates the predicted queue, returns the result it causes
    function automatic result_t receive_beat(op_t op, logic [BYTE_BITS-1:0] data);
        result_t r;
        hdr_t    slot;
        int      pos;
        r = '0;
        if (op == OP_BYTE) begin
            pos = rx_pos;
            if (pos >= HDR_BYTES) begin
                r.payload_valid = 1'b1;
                r.payload_byte  = data;
                r.payload_index = LEN_W'(pos - HDR_BYTES);
            end else if (pos == POS_MODULE) begin
                rx_mod = data;
            end else if (pos == POS_FUNCTION) begin
                rx_func = data;
            end else if (pos == LEN_LO_POS) begin
                rx_len = LEN_W'(data);
            end else begin
                rx_len = {data, rx_len[BYTE_BITS-1:0]};
            end
            pos++;
            if (pos >= HDR_BYTES + int'(rx_len)) begin
                r.frame_done = 1'b1;
                if (ring_fill >= QUEUE_DEPTH) begin
                    r.frame_dropped = 1'b1;
                end else begin
                    slot.mod_id  = rx_mod;
                    slot.func_id = rx_func;
                    slot.len     = rx_len;
                    hdr_ring[ring_wr] = slot;
                    ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
                    ring_fill++;
                end
                pos    = 0;
                rx_len = '0;
            end
            rx_pos = pos;
        end else if (ring_fill == 0) begin
            r.pop_error = 1'b1;
        end else begin
            r.cmd_valid    = 1'b1;
            r.cmd_target   = hdr_ring[ring_rd].mod_id;
            r.cmd_function = hdr_ring[ring_rd].func_id;
            r.cmd_length   = hdr_ring[ring_rd].len;
            ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
            ring_fill--;
        end
        r.queue_count = QCOUNT_W'(ring_fill);
        r.queue_full  = (ring_fill == QUEUE_DEPTH);
        return r;
    endfunction

    function automatic string differing_fields(result_t exp_r, result_t act_r);
        string s;
        s = "";
        if (act_r.payload_valid !== exp_r.payload_valid) s = {s, " payload_valid"};
        if (act_r.payload_byte  !== exp_r.payload_byte)  s = {s, " payload_byte"};
        if (act_r.payload_index !== exp_r.payload_index) s = {s, " payload_index"};
        if (act_r.frame_done    !== exp_r.frame_done)    s = {s, " frame_done"};
        if (act_r.frame_dropped !== exp_r.frame_dropped) s = {s, " frame_dropped"};
        if (act_r.cmd_valid     !== exp_r.cmd_valid)     s = {s, " cmd_valid"};
        if (act_r.cmd_target    !== exp_r.cmd_target)    s = {s, " cmd_target"};
        if (act_r.cmd_function  !== exp_r.cmd_function)  s = {s, " cmd_function"};
        if (act_r.cmd_length    !== exp_r.cmd_length)    s = {s, " cmd_length"};
        if (act_r.pop_error     !== exp_r.pop_error)     s = {s, " pop_error"};
        if (act_r.queue_count   !== exp_r.queue_count)   s = {s, " queue_count"};
        if (act_r.queue_full    !== exp_r.queue_full)    s = {s, " queue_full"};
        return s;
    endfunction

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void send_byte(logic [BYTE_BITS-1:0] b);
        rx_item_t it;
        it.drain = 1'b0;
        it.op    = OP_BYTE;
        it.data  = b;
        tx_beats.push_back(it);
    endfunction

    function automatic void send_pop();
        rx_item_t it;
        it.drain = 1'b0;
        it.op    = OP_POP;
        it.data  = BYTE_BITS'($urandom_range(0, 255));
        tx_beats.push_back(it);
    endfunction

    function automatic void send_settle();
        rx_item_t it;
        it       = '0;
        it.drain = 1'b1;
        tx_beats.push_back(it);
    endfunction

    // a well-formed frame with random payload, pops slipped in between bytes
    function automatic void send_frame(logic [BYTE_BITS-1:0] mod_id,
                                       logic [BYTE_BITS-1:0] func_id,
                                       logic [LEN_W-1:0] len, int pop_pct);
        logic [BYTE_BITS-1:0] hdr_bytes [HDR_BYTES];
        hdr_bytes[POS_MODULE]   = mod_id;
        hdr_bytes[POS_FUNCTION] = func_id;
        hdr_bytes[LEN_LO_POS]   = len[BYTE_BITS-1:0];
        hdr_bytes[LEN_HI_POS]   = len[LEN_W-1:BYTE_BITS];
        for (int i = 0; i < HDR_BYTES + int'(len); i++) begin
            if (i > 0 && $urandom_range(0, 99) < pop_pct)
                send_pop();
            if (i < HDR_BYTES)
                send_byte(hdr_bytes[i]);
            else
                send_byte(BYTE_BITS'($urandom_range(0, 255)));
        end
    endfunction

    // request side: feeds tx_beats, predicts each accepted beat
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid     <= 1'b0;
            req_ch.operation <= OP_BYTE;
            req_ch.rx_byte   <= '0;
            send_gap  = 0;
            rx_pos    = 0;
            rx_len    = '0;
            rx_mod    = '0;
            rx_func   = '0;
            ring_wr   = 0;
            ring_rd   = 0;
            ring_fill = 0;
        end else begin
            if (req_ch.valid && req_ch.ready)
                due_results.push_back(receive_beat(op_t'(req_ch.operation), req_ch.rx_byte));

            if (req_ch.valid && !req_ch.ready) begin
                // beat still offered, hold it
            end else if (send_gap > 0) begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end else if (tx_beats.size() != 0 && tx_beats[0].drain) begin
                req_ch.valid <= 1'b0;
                if (due_results.size() == 0)
                    void'(tx_beats.pop_front());
            end else if (tx_beats.size() != 0) begin
                next_item = tx_beats.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.operation <= next_item.op;
                req_ch.rx_byte   <= next_item.data;
                send_gap = pick_gap();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // result side: random stalls plus one long hold, checks every accepted beat
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   = 0;
            hold_done    = 1'b0;
            results_seen = 0;
            error_count  = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                seen.payload_valid = rsp_ch.payload_valid;
                seen.payload_byte  = rsp_ch.payload_byte;
                seen.payload_index = rsp_ch.payload_index;
                seen.frame_done    = rsp_ch.frame_done;
                seen.frame_dropped = rsp_ch.frame_dropped;
                seen.cmd_valid     = rsp_ch.cmd_valid;
                seen.cmd_target    = rsp_ch.cmd_target;
                seen.cmd_function  = rsp_ch.cmd_function;
                seen.cmd_length    = rsp_ch.cmd_length;
                seen.pop_error     = rsp_ch.pop_error;
                seen.queue_count   = rsp_ch.queue_count;
                seen.queue_full    = rsp_ch.queue_full;
                results_seen++;
                if (due_results.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("result %0d arrived with nothing expected: %p",
                                 results_seen, seen);
                end else begin
                    want = due_results.pop_front();
                    bad_fields = differing_fields(want, seen);
                    if (bad_fields != "") begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result %0d differs in%s\n  expected %p\n  actual   %p",
                                     results_seen, bad_fields, want, seen);
                    end
                end
            end

            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
            end

            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        int       random_items;
        int       start_size;
        int       run_idx;
        int       roll;
        int       pops;
        int       mode;
        logic [LEN_W-1:0] len;

        rst_n = 1'b0;

        // pop on an empty queue
        send_pop();
        // zero-length frame with extreme header bytes
        send_frame(8'h00, 8'hFF, 16'd0, 0);
        // three-byte payload; pops in the header and in the payload leave the parser alone
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h03);
        send_pop();
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_pop();
        send_byte(8'hA5);
        // one-byte payload, pop right after the module byte
        send_byte(8'h5A);
        send_pop();
        send_byte(8'hA5);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h80);
        // one header left, then an empty pop
        send_pop();
        send_pop();
        send_settle();

        // a frame past 255 payload bytes, so the length high byte is in use
        send_frame(8'hFF, 8'hFF, 16'h0100, 0);
        send_settle();

        // runs of frames: fill (queue overflows), balanced, drain (empty pops)
        random_items = 0;
        run_idx      = 0;
        while (random_items < RANDOM_ITEMS) begin
            mode = run_idx % 3;
            for (int k = 0; k < FRAMES_PER_RUN; k++) begin
                start_size = tx_beats.size();
                roll = $urandom_range(0, 99);
                if (roll < 75)
                    len = LEN_W'($urandom_range(0, 4));
                else if (roll < 95)
                    len = LEN_W'($urandom_range(5, 20));
                else
                    len = LEN_W'($urandom_range(21, 300));
                send_frame(BYTE_BITS'($urandom_range(0, 255)),
                           BYTE_BITS'($urandom_range(0, 255)),
                           len, (mode == 0) ? 1 : 8);
                if (mode == 0)
                    pops = 0;
                else if (mode == 1)
                    pops = $urandom_range(0, 2);
                else
                    pops = $urandom_range(1, 4);
                repeat (pops) send_pop();
                random_items += tx_beats.size() - start_size;
            end
            if (run_idx % 2 == 1 || $urandom_range(0, 3) == 0)
                send_settle();
            run_idx++;
        end
        // leave the queue empty
        repeat (QUEUE_DEPTH + 1) send_pop();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (tx_beats.size() != 0 || due_results.size() != 0 || req_ch.valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // far beyond the slowest legal run
    initial begin
        #150_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
